// ===== design/rsf_pkg.sv =====
`default_nettype none

package rsf_pkg;

    localparam int MAX_LEN = 32;
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int POS_W   = $clog2(MAX_LEN + 1);
    localparam int BASE_W  = 3;
    localparam int FLD_W   = 5;
    localparam int CFG_W   = 5;

    localparam logic [BASE_W-1:0] BASE_A = 3'd0;
    localparam logic [BASE_W-1:0] BASE_C = 3'd1;
    localparam logic [BASE_W-1:0] BASE_G = 3'd2;
    localparam logic [BASE_W-1:0] BASE_U = 3'd3;

    localparam logic REG_MIN_STEM = 1'b0;
    localparam logic REG_MIN_DIST = 1'b1;

    localparam logic [CFG_W-1:0] MIN_STEM_RST = 5'd3;
    localparam logic [CFG_W-1:0] MIN_DIST_RST = 5'd4;

    typedef struct packed {
        logic             ovf;
        logic [FLD_W-1:0] stem_len;
        logic [FLD_W-1:0] three_p;
        logic [FLD_W-1:0] five_p;
    } t_stem;

    // Watson-Crick pairs plus the G-U wobble, in either order
    function automatic logic can_pair(input logic [BASE_W-1:0] a, input logic [BASE_W-1:0] b);
        logic ok;
        ok = 1'b0;
        case (a)
            BASE_A: ok = (b == BASE_U);
            BASE_C: ok = (b == BASE_G);
            BASE_G: ok = (b == BASE_C) || (b == BASE_U);
            BASE_U: ok = (b == BASE_A) || (b == BASE_G);
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

`default_nettype wire

// ===== design/rna_stem_finder_top.sv =====
`default_nettype none

// Channel   Dir  Handshake               Payload (low bit up)
// s_axis    in   tvalid/tready           tdata: base[2:0], zero fill; tlast: last base
// m_axis    out  tvalid/tready           tdata: five_prime, three_prime, stem_length, zero;
//                                        tuser: overflow; tlast: last result of the item
// cfg       in   we (no handshake back)  idx 0 min_stem_length, 1 min_pair_distance
//
// A base stored at position j scans the column memory one entry per cycle while the
// output has room, then runs the edge stem and flush states before the next transfer.
// A last base adds the end scan and a state for the overflow marker.
// A dropped base runs the marker and flush states, after the end scan if it has tlast.
// Any result that cannot move into the full output stage stalls the scan in place.
// Reset is synchronous; no clearing pass: the fill position marks which entries are live.
module rna_stem_finder_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  wire logic [7:0]                    i_s_axis_tdata,  // base[2:0], fill
    input  wire logic                          i_s_axis_tlast,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    output logic [15:0]                        o_m_axis_tdata,  // five, three, length, fill
    output logic                               o_m_axis_tuser,  // overflow
    output logic                               o_m_axis_tlast,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_idx,
    input  wire logic [rsf_pkg::CFG_W-1:0]     i_cfg_data
);
    import rsf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_COL, S_EDGE, S_END, S_ZERO, S_FLUSH
    } t_state;

    t_state r_state;

    logic [FLD_W-1:0]  col_mem  [MAX_LEN];
    logic [BASE_W-1:0] base_mem [MAX_LEN];

    logic [FLD_W-1:0]  r_col_rd;
    logic [BASE_W-1:0] r_base_rd;

    logic [CFG_W-1:0]  r_min;
    logic [CFG_W-1:0]  r_dist;
    logic [POS_W-1:0]  r_pos;
    logic [IDX_W-1:0]  r_j;
    logic [BASE_W-1:0] r_b;
    logic              r_last;
    logic              r_ov;
    logic [POS_W-1:0]  r_ri;
    logic              r_cv;
    logic [IDX_W-1:0]  r_ci;
    logic [FLD_W-1:0]  r_col0;
    logic              r_any;
    logic              r_pend_v;
    t_stem             r_pend;
    logic              r_m_valid;
    t_stem             r_m_data;
    logic              r_m_last;

    logic              accept;
    logic              in_ov;
    logic              out_free;
    logic              can_push;
    logic              emit;
    t_stem             stem;
    logic              adv;
    logic              issue_ok;
    logic              rd_en;
    logic [IDX_W-1:0]  col_ra;
    logic              col_we;
    logic [IDX_W-1:0]  col_wa;
    logic [FLD_W-1:0]  col_wd;
    logic [FLD_W-1:0]  new_v;
    logic [CFG_W-1:0]  eff_dist;
    logic              dist_ok;
    logic              flush_go;
    logic [POS_W-1:0]  n_pos;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign in_ov           = (r_pos == POS_W'(MAX_LEN));
    assign out_free        = !r_m_valid || i_m_axis_tready;
    assign can_push        = !r_pend_v || out_free;
    assign eff_dist        = (r_dist == '0) ? CFG_W'(1) : r_dist;
    assign dist_ok         = (CFG_W'(r_j - r_ci) >= eff_dist);
    assign n_pos           = r_pos + POS_W'(1);

    always_comb begin
        emit  = 1'b0;
        stem  = '0;
        new_v = '0;
        if (can_pair(r_base_rd, r_b) && dist_ok) begin
            new_v = r_col_rd + FLD_W'(1);
        end
        case (r_state)
            S_COL: begin
                emit = r_cv && dist_ok && (new_v == '0) && (r_col_rd > r_min);
                stem.five_p   = FLD_W'(r_ci) + FLD_W'(1);
                stem.three_p  = FLD_W'(r_j) - FLD_W'(1);
                stem.stem_len = r_col_rd;
            end
            S_EDGE: begin
                emit = (r_col0 > r_min);
                stem.three_p  = FLD_W'(r_j);
                stem.stem_len = r_col0;
            end
            S_END: begin
                emit = r_cv && (r_col_rd > r_min);
                stem.five_p   = FLD_W'(r_ci);
                stem.three_p  = FLD_W'(r_pos - POS_W'(1));
                stem.stem_len = r_col_rd;
                stem.ovf      = r_ov;
            end
            S_ZERO: begin
                emit     = r_ov && !r_any;
                stem.ovf = 1'b1;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        adv = !emit || can_push;

        issue_ok = 1'b0;
        col_ra   = r_ri[IDX_W-1:0];
        if (r_state == S_COL) begin
            issue_ok = (r_ri < {1'b0, r_j});
            col_ra   = IDX_W'(r_ri + POS_W'(1));
        end else if (r_state == S_END) begin
            issue_ok = (r_ri < r_pos);
        end
        rd_en = adv && issue_ok;

        // the new diagonal slot starts at zero; the scan rewrites the rows below it
        col_we = 1'b0;
        col_wa = r_ci;
        col_wd = new_v;
        if (accept && !in_ov) begin
            col_we = 1'b1;
            col_wa = r_pos[IDX_W-1:0];
            col_wd = '0;
        end else if (r_state == S_COL && r_cv && adv) begin
            col_we = 1'b1;
        end

        flush_go = (r_state == S_FLUSH) && r_pend_v && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (col_we) begin
            col_mem[col_wa] <= col_wd;
        end
        if (accept && !in_ov) begin
            base_mem[r_pos[IDX_W-1:0]] <= i_s_axis_tdata[BASE_W-1:0];
        end
        if (rd_en) begin
            r_col_rd  <= col_mem[col_ra];
            r_base_rd <= base_mem[r_ri[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_min     <= MIN_STEM_RST;
            r_dist    <= MIN_DIST_RST;
            r_pos     <= '0;
            r_cv      <= 1'b0;
            r_pend_v  <= 1'b0;
            r_m_valid <= 1'b0;
            r_any     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MIN_STEM: r_min  <= i_cfg_data;
                    REG_MIN_DIST: r_dist <= i_cfg_data;
                    default: ;
                endcase
            end

            // output stage and the one-deep holding slot that lets tlast be known
            if (emit && adv) begin
                r_any <= 1'b1;
                r_pend <= stem;
                r_pend_v <= 1'b1;
                if (r_pend_v) begin
                    r_m_valid <= 1'b1;
                    r_m_data  <= r_pend;
                    r_m_last  <= 1'b0;
                end else if (r_m_valid && i_m_axis_tready) begin
                    r_m_valid <= 1'b0;
                end
            end else if (flush_go) begin
                r_m_valid <= 1'b1;
                r_m_data  <= r_pend;
                r_m_last  <= 1'b1;
                r_pend_v  <= 1'b0;
            end else if (r_m_valid && i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            if (rd_en) begin
                r_ri <= r_ri + POS_W'(1);
                r_ci <= r_ri[IDX_W-1:0];
            end
            // no read is issued in idle or edge, so this also clears r_cv there
            if (adv) begin
                r_cv <= rd_en;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_b    <= i_s_axis_tdata[BASE_W-1:0];
                        r_last <= i_s_axis_tlast;
                        r_ov   <= in_ov;
                        r_j    <= r_pos[IDX_W-1:0];
                        r_col0 <= '0;
                        r_any  <= 1'b0;
                        if (!in_ov) begin
                            r_pos   <= n_pos;
                            r_ri    <= '0;
                            r_state <= S_COL;
                        end else if (i_s_axis_tlast) begin
                            r_ri    <= POS_W'(1);
                            r_state <= S_END;
                        end else begin
                            r_state <= S_ZERO;
                        end
                    end
                end
                S_COL: begin
                    if (r_cv && adv && r_ci == '0) begin
                        r_col0 <= new_v;
                    end
                    if (adv && !issue_ok) begin
                        r_state <= S_EDGE;
                    end
                end
                S_EDGE: begin
                    if (adv) begin
                        if (r_last) begin
                            r_ri    <= POS_W'(1);
                            r_state <= S_END;
                        end else begin
                            r_state <= S_FLUSH;
                        end
                    end
                end
                S_END: begin
                    if (adv && !issue_ok) begin
                        r_pos   <= '0;
                        r_state <= S_ZERO;
                    end
                end
                S_ZERO: begin
                    if (adv) begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    if (!r_pend_v || out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {1'b0, r_m_data.stem_len, r_m_data.three_p, r_m_data.five_p};
    assign o_m_axis_tuser  = r_m_data.ovf;
    assign o_m_axis_tlast  = r_m_last;

endmodule

`default_nettype wire

// ===== tb/sv/tb_rna_stem_finder_top.sv =====
module tb_rna_stem_finder_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rsf_pkg::*;

    localparam logic [BASE_W-1:0] BASE_N = 3'd4;   // any symbol, never pairs
    localparam int SETTLE_CYCLES = 120;
    localparam int PHASE_BASES   = 24;
    localparam int N_PHASES      = 7;

    typedef struct packed {
        logic [FLD_W-1:0] five;
        logic [FLD_W-1:0] three;
        logic [FLD_W-1:0] len;
        logic             ovf;
        logic             lst;
    } t_stem_rec;

    typedef struct packed {
        logic [BASE_W-1:0] b;
        logic              lst;
        logic [5:0]        reps;
        logic              typed;
        t_stem_rec         want;
    } t_plan_row;

    localparam t_stem_rec NO_STEM  = '0;
    localparam t_stem_rec OVF_ONLY = '{five: 5'd0, three: 5'd0, len: 5'd0, ovf: 1'b1, lst: 1'b1};

    localparam t_plan_row DIRECTED [13] = '{
        // GGGG AAAA CCCC, reset thresholds: one edge stem of 4 at the last base
        '{BASE_G, 1'b0, 6'd4, 1'b0, NO_STEM},
        '{BASE_A, 1'b0, 6'd4, 1'b0, NO_STEM},
        '{BASE_C, 1'b0, 6'd3, 1'b0, NO_STEM},
        '{BASE_C, 1'b1, 6'd1, 1'b1, '{5'd0, 5'd11, 5'd4, 1'b0, 1'b1}},
        // lone base that is also the last one
        '{BASE_U, 1'b1, 6'd1, 1'b0, NO_STEM},
        // A GGGGG AAA CCCCC: interior and end stems
        '{BASE_A, 1'b0, 6'd1, 1'b0, NO_STEM},
        '{BASE_G, 1'b0, 6'd5, 1'b0, NO_STEM},
        '{BASE_A, 1'b0, 6'd3, 1'b0, NO_STEM},
        '{BASE_C, 1'b0, 6'd4, 1'b0, NO_STEM},
        '{BASE_C, 1'b1, 6'd1, 1'b0, NO_STEM},
        // fill storage, then drop one base without and one with last
        '{BASE_N, 1'b0, 6'd32, 1'b0, NO_STEM},
        '{BASE_U, 1'b0, 6'd1, 1'b1, OVF_ONLY},
        '{BASE_A, 1'b1, 6'd1, 1'b1, OVF_ONLY}
    };

    localparam logic [CFG_W-1:0] PHASE_LEN  [N_PHASES] = '{5'd0, 5'd1, 5'd2, 5'd31, 5'd0, 5'd4, 5'd3};
    localparam logic [CFG_W-1:0] PHASE_DIST [N_PHASES] = '{5'd1, 5'd0, 5'd3, 5'd31, 5'd31, 5'd2, 5'd4};

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = 8'd0;
    logic              s_tlast  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [15:0]       m_tdata;
    logic              m_tuser;
    logic              m_tlast;
    logic              cfg_we   = 1'b0;
    logic              cfg_idx  = 1'b0;
    logic [CFG_W-1:0]  cfg_data = '0;

    // stem predictor state
    logic [BASE_W-1:0] seq_base [MAX_LEN];
    logic [FLD_W-1:0]  run_len  [MAX_LEN];
    int                fill;
    logic [CFG_W-1:0]  thr_len;
    logic [CFG_W-1:0]  thr_dist;

    t_stem_rec new_stems [$];
    t_stem_rec pending_stems [$];

    int   bases_sent = 0;
    int   stems_seen = 0;
    int   mismatches = 0;
    logic src_gaps   = 1'b1;
    logic sink_gaps  = 1'b1;

    rna_stem_finder_top uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // base[2:0], zero fill
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // five_prime, three_prime, stem_length, zero fill
        .o_m_axis_tuser  (m_tuser),   // overflow
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial begin
        #8_000_000;
        $display("Mismatches found");
        $finish;
    end

    // A-U and C-G sum to 3, the G-U wobble to 5; codes above U never pair
    function automatic logic pairs_with(input logic [BASE_W-1:0] a, input logic [BASE_W-1:0] b);
        return a <= BASE_U && b <= BASE_U && (a + b == 3 || a + b == 5);
    endfunction

    function automatic void add_stem(input int f, input int t, input logic [FLD_W-1:0] n,
                                     input logic ov);
        t_stem_rec rec;
        rec = '{five: 5'(f), three: 5'(t), len: n, ovf: ov, lst: 1'b0};
        new_stems = {new_stems, rec};
    endfunction

    function automatic void reset_predictor();
        foreach (run_len[k]) begin
            run_len[k]  = '0;
            seq_base[k] = '0;
        end
        fill     = 0;
        thr_len  = MIN_STEM_RST;
        thr_dist = MIN_DIST_RST;
    endfunction

    // stems caused by one base, left in new_stems
    function automatic void predict_stems(input logic [BASE_W-1:0] b, input logic lst);
        logic [FLD_W-1:0] prev [MAX_LEN];
        logic [FLD_W-1:0] v;
        logic             ovf;
        int               gap_min;
        int               j;
        new_stems.delete();
        gap_min = (thr_dist == 0) ? 1 : int'(thr_dist);
        ovf  = (fill >= MAX_LEN);
        if (!ovf) begin
            j    = fill;
            prev = run_len;
            seq_base[j] = b;
            for (int i = 0; i < j; i++) begin
                v = '0;
                if (j - i >= gap_min) begin
                    if (pairs_with(seq_base[i], b))
                        v = prev[i+1] + 5'd1;
                    // run on this diagonal just stopped growing
                    if (v == 0 && prev[i+1] > thr_len)
                        add_stem(i + 1, j - 1, prev[i+1], 1'b0);
                end
                run_len[i] = v;
            end
            run_len[j] = '0;
            if (run_len[0] > thr_len)
                add_stem(0, j, run_len[0], 1'b0);
            fill = j + 1;
        end
        if (lst) begin
            for (int i = 1; i < fill; i++)
                if (run_len[i] > thr_len)
                    add_stem(i, fill - 1, run_len[i], ovf);
            foreach (run_len[k])
                run_len[k] = '0;
            fill = 0;
        end
        if (ovf && new_stems.size() == 0)
            add_stem(0, 0, '0, 1'b1);
        if (new_stems.size() > 0)
            new_stems[new_stems.size() - 1].lst = 1'b1;
    endfunction

    function automatic logic [BASE_W-1:0] any_base();
        return 3'($urandom_range(0, 4));
    endfunction

    function automatic logic [BASE_W-1:0] partner(input logic [BASE_W-1:0] b);
        case (b)
            BASE_A: return BASE_U;
            BASE_C: return BASE_G;
            BASE_G: return $urandom_range(0, 1) ? BASE_U : BASE_C;
            default: return $urandom_range(0, 1) ? BASE_G : BASE_A;
        endcase
    endfunction

    task automatic push_base(input logic [BASE_W-1:0] b, input logic lst, input logic typed,
                             input t_stem_rec want);
        int gap;
        gap = src_gaps ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, b};
        s_tlast  <= lst;
        do @(posedge clk); while (!s_tready);
        bases_sent++;
        predict_stems(b, lst);
        if (typed)
            pending_stems = {pending_stems, want};
        else
            pending_stems = {pending_stems, new_stems};
    endtask

    // mostly hairpins with random arms and loops, some plain noise
    task automatic send_strand();
        logic [BASE_W-1:0] strand [$];
        logic [BASE_W-1:0] arm [$];
        logic [BASE_W-1:0] b;
        int                loops;
        src_gaps = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 9) < 7) begin
            loops = $urandom_range(1, 2);
            repeat (loops) begin
                arm.delete();
                repeat ($urandom_range(0, 3)) strand = {strand, any_base()};
                repeat ($urandom_range(1, 8)) begin
                    arm    = {arm, 3'($urandom_range(0, 3))};
                    strand = {strand, arm[arm.size() - 1]};
                end
                repeat ($urandom_range(0, 6)) strand = {strand, any_base()};
                while (arm.size() > 0) begin
                    b = arm.pop_back();
                    if ($urandom_range(0, 11) == 0)
                        b = any_base();
                    else
                        b = partner(b);
                    strand = {strand, b};
                end
            end
            repeat ($urandom_range(0, 3)) strand = {strand, any_base()};
        end else begin
            repeat (($urandom_range(0, 5) == 0) ? $urandom_range(30, 38) : $urandom_range(1, 16))
                strand = {strand, any_base()};
        end
        foreach (strand[k])
            push_base(strand[k], k == strand.size() - 1, 1'b0, NO_STEM);
    endtask

    task automatic compare_field(input string name, input logic [FLD_W-1:0] want,
                                 input logic [FLD_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_stem();
        t_stem_rec got;
        t_stem_rec want;
        got = '{five: m_tdata[4:0], three: m_tdata[9:5], len: m_tdata[14:10],
                ovf: m_tuser, lst: m_tlast};
        stems_seen++;
        if (pending_stems.size() == 0) begin
            $display("%0t ns: result with none expected (five %0d three %0d len %0d)",
                     $time, got.five, got.three, got.len);
            mismatches++;
        end else begin
            want = pending_stems[0];
            pending_stems.delete(0);
            compare_field("five_prime", want.five, got.five);
            compare_field("three_prime", want.three, got.three);
            compare_field("stem_length", want.len, got.len);
            compare_field("overflow", FLD_W'(want.ovf), FLD_W'(got.ovf));
            compare_field("last_of_run", FLD_W'(want.lst), FLD_W'(got.lst));
        end
    endtask

    task automatic drain();
        while (pending_stems.size() != 0)
            @(posedge clk);
        // a base that causes no stem may still be scanning
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_thresholds(input logic [CFG_W-1:0] len, input logic [CFG_W-1:0] dist_v);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_MIN_STEM;
        cfg_data <= len;
        @(posedge clk);
        cfg_idx  <= REG_MIN_DIST;
        cfg_data <= dist_v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        thr_len  = len;
        thr_dist = dist_v;
        @(posedge clk);
    endtask

    initial begin : sink
        int hold;
        int left;
        left = 0;
        @(posedge rst_n);
        forever begin
            if (left == 0) begin
                sink_gaps = ($urandom_range(0, 2) != 0);
                left      = $urandom_range(4, 24);
            end
            left--;
            hold = sink_gaps ? $urandom_range(0, 5) : 0;
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            check_stem();
        end
    end

    initial begin : source
        int goal;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        reset_predictor();
        @(posedge clk);

        for (int r = 0; r < $size(DIRECTED); r++)
            repeat (DIRECTED[r].reps)
                push_base(DIRECTED[r].b, DIRECTED[r].lst, DIRECTED[r].typed, DIRECTED[r].want);
        s_tvalid <= 1'b0;

        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            set_thresholds(PHASE_LEN[p], PHASE_DIST[p]);
            goal = bases_sent + PHASE_BASES;
            while (bases_sent < goal)
                send_strand();
            s_tvalid <= 1'b0;
        end
        drain();

        $display("Sent %0d bases under reset and %0d written threshold settings, %0d stems checked.",
                 bases_sent, N_PHASES, stems_seen);
        $display("Edge, interior and end stems, storage overflow and random stalls were exercised.");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
design/rsf_pkg.sv
design/rna_stem_finder_top.sv
tb/sv/tb_rna_stem_finder_top.sv
